// ===== design/proximity_blink_led_controller_assert.svh =====
// assertion macros for the proximity blink led controller
// used by the controller and datapath modules, no other dependencies
`ifndef PROXIMITY_BLINK_LED_CONTROLLER_ASSERT_SVH
`define PROXIMITY_BLINK_LED_CONTROLLER_ASSERT_SVH

// consequent checked in the same cycle
`define PBLC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define PBLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pblc_pkg.sv =====
// shared types and constants of the proximity blink led controller
// no dependencies
`timescale 1ns / 1ps

package pblc_pkg;

  // timing constants in milliseconds
  localparam logic [15:0] FLASH_STEP_MS = 16'd150;
  localparam logic [15:0] IDLE_POLL_MS  = 16'd100;

  // detection state after reset: strength of minus one hundred
  localparam logic signed [7:0] STRENGTH_RESET = 8'sh9C;

  // age counter saturates here
  localparam logic [16:0] AGE_MAX = 17'h1FFFF;

  // interpolation divider: dividend width, one quotient bit per step
  localparam int PROD_W    = 24;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // request kinds
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_NOTICE = 2'd1,
    MODE_FLASH  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_RSSI_NEAR    = 3'd0,
    REG_RSSI_FAR     = 3'd1,
    REG_FAST_HALF_MS = 3'd2,
    REG_SLOW_HALF_MS = 3'd3,
    REG_HOLD_MS      = 3'd4,
    REG_BRIGHTNESS   = 3'd5
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } ctrl_state_t;

  // input request payload
  typedef struct packed {
    mode_t             mode;
    logic signed [7:0] notify_rssi;
    logic              alert_kind;
    logic [7:0]        flash_red;
    logic [7:0]        flash_green;
    logic [7:0]        flash_blue;
    logic signed [7:0] flash_count;
  } item_t;

  // result payload
  typedef struct packed {
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
  } led_t;

  // configuration registers
  typedef struct packed {
    logic signed [7:0] rssi_near;
    logic signed [7:0] rssi_far;
    logic [15:0]       fast_half_ms;
    logic [15:0]       slow_half_ms;
    logic [15:0]       hold_ms;
    logic [7:0]        brightness;
  } cfg_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic div_step;
    logic fin;
    logic load_out;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_div;
  } dp_status_t;

endpackage

// ===== design/pblc_dp.sv =====
// datapath: led state, flash playback, detection age and half period divider
// depends on pblc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "proximity_blink_led_controller_assert.svh"

module pblc_dp (
  input  logic                clk,
  input  logic                rst,
  input  pblc_pkg::cfg_t      cfg,
  input  pblc_pkg::item_t     item,
  input  pblc_pkg::dp_cmd_t   cmd,
  output pblc_pkg::dp_status_t status,
  output pblc_pkg::led_t      led
);
  import pblc_pkg::*;

  // request held while it is worked on
  item_t item_q;

  // model state
  logic [15:0]       wait_left;
  logic              white_phase;
  logic signed [7:0] last_strength;
  logic              last_kind;
  logic              seen_valid;
  logic [16:0]       age_count;
  logic [7:0]        pending_flashes;
  logic [23:0]       pending_colour;
  logic [7:0]        playing_flashes;
  logic [23:0]       playing_colour;
  logic              flash_lit;
  logic [23:0]       led_colour;

  // divider state
  logic [PROD_W-1:0] div_dvd;
  logic [7:0]        rem;
  logic [7:0]        span_q;
  logic              prod_neg;

  // tick arithmetic
  logic        is_tick;
  logic [16:0] age_inc;
  logic [15:0] wait_dec;
  logic [7:0]  play_dec;
  logic        decide;
  logic        blink_on;
  logic        white_next;
  logic [23:0] blink_colour;
  logic [7:0]  b;

  always_comb begin
    is_tick    = (item_q.mode == MODE_TICK);
    age_inc    = (age_count != AGE_MAX) ? age_count + 17'd1 : age_count;
    wait_dec   = wait_left - {15'd0, (wait_left != 16'd0)};
    play_dec   = playing_flashes - {7'd0, (playing_flashes != 8'd0)};
    decide     = is_tick && (wait_dec == 16'd0);
    blink_on   = seen_valid && (age_inc <= {1'b0, cfg.hold_ms});
    white_next = !white_phase;
    b          = cfg.brightness;
    if (white_next) begin
      blink_colour = {b, b, b};
    end else if (last_kind) begin
      blink_colour = {16'd0, b};
    end else begin
      blink_colour = {b, 16'd0};
    end
  end

  // clamp and interpolation operands
  logic              window_ok;
  logic signed [7:0] r_clamp;
  logic signed [8:0] span_w;
  logic signed [8:0] pos_w;
  logic [7:0]        span;
  logic [7:0]        pos;
  logic signed [16:0] diff;
  logic              diff_neg;
  logic [15:0]       diff_mag;
  logic [PROD_W-1:0] prod;

  always_comb begin
    window_ok = (cfg.rssi_near > cfg.rssi_far);
    r_clamp   = last_strength;
    if (r_clamp > cfg.rssi_near) begin
      r_clamp = cfg.rssi_near;
    end
    if (r_clamp < cfg.rssi_far) begin
      r_clamp = cfg.rssi_far;
    end
    span_w   = {cfg.rssi_near[7], cfg.rssi_near} - {cfg.rssi_far[7], cfg.rssi_far};
    pos_w    = {r_clamp[7], r_clamp} - {cfg.rssi_far[7], cfg.rssi_far};
    span     = span_w[7:0];
    pos      = pos_w[7:0];
    diff     = $signed({1'b0, cfg.slow_half_ms}) - $signed({1'b0, cfg.fast_half_ms});
    diff_neg = diff[16];
    diff_mag = diff_neg ? 16'(-diff) : diff[15:0];
    prod     = {16'd0, pos} * {8'd0, diff_mag};
  end

  // blink decision that needs the divider
  assign status.need_div = decide && !flash_lit && (play_dec == 8'd0) &&
                           (pending_flashes == 8'd0) && blink_on && window_ok;

  // one restoring division step
  logic [8:0] rem_sh;
  logic [8:0] rem_sub;
  logic       rem_ge;

  always_comb begin
    rem_sh  = {rem, div_dvd[PROD_W-1]};
    rem_sub = rem_sh - {1'b0, span_q};
    rem_ge  = (rem_sh >= {1'b0, span_q});
  end

  // half period from the quotient, sign restored
  logic [15:0] interp_half;
  assign interp_half = prod_neg ? cfg.slow_half_ms + div_dvd[15:0]
                                : cfg.slow_half_ms - div_dvd[15:0];

  // request capture and divider registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_q <= item;
    end
    if (cmd.exec) begin
      div_dvd  <= prod;
      rem      <= 8'd0;
      span_q   <= span;
      prod_neg <= diff_neg;
    end else if (cmd.div_step) begin
      div_dvd <= {div_dvd[PROD_W-2:0], rem_ge};
      rem     <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

  // model state update
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_left       <= 16'd0;
      white_phase     <= 1'b0;
      last_strength   <= STRENGTH_RESET;
      last_kind       <= 1'b0;
      seen_valid      <= 1'b0;
      age_count       <= 17'd0;
      pending_flashes <= 8'd0;
      pending_colour  <= 24'd0;
      playing_flashes <= 8'd0;
      playing_colour  <= 24'd0;
      flash_lit       <= 1'b0;
      led_colour      <= 24'd0;
    end else if (cmd.exec) begin
      case (item_q.mode)
        MODE_TICK: begin
          age_count <= age_inc;
          wait_left <= wait_dec;
          if (decide) begin
            if (flash_lit) begin
              // end of a lit flash step
              flash_lit  <= 1'b0;
              led_colour <= 24'd0;
              wait_left  <= FLASH_STEP_MS;
            end else begin
              playing_flashes <= play_dec;
              if (play_dec != 8'd0) begin
                // next flash of the running playback
                flash_lit  <= 1'b1;
                led_colour <= playing_colour;
                wait_left  <= FLASH_STEP_MS;
              end else if (pending_flashes != 8'd0) begin
                // start the waiting flash request
                playing_flashes <= pending_flashes;
                playing_colour  <= pending_colour;
                pending_flashes <= 8'd0;
                white_phase     <= 1'b0;
                flash_lit       <= 1'b1;
                led_colour      <= pending_colour;
                wait_left       <= FLASH_STEP_MS;
              end else if (blink_on) begin
                // proximity blink, interpolated wait set at finish, slow half period if the window is empty
                white_phase <= white_next;
                led_colour  <= blink_colour;
                if (!window_ok) begin
                  wait_left <= cfg.slow_half_ms;
                end
              end else begin
                led_colour  <= 24'd0;
                white_phase <= 1'b0;
                wait_left   <= IDLE_POLL_MS;
              end
            end
          end
        end
        MODE_NOTICE: begin
          last_strength <= item_q.notify_rssi;
          last_kind     <= item_q.alert_kind;
          age_count     <= 17'd0;
          seen_valid    <= 1'b1;
        end
        MODE_FLASH: begin
          pending_colour  <= {item_q.flash_red, item_q.flash_green, item_q.flash_blue};
          pending_flashes <= (!item_q.flash_count[7]) ? item_q.flash_count : 8'd0;
        end
        default: begin
        end
      endcase
    end else if (cmd.fin) begin
      wait_left <= interp_half;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      led <= led_t'(led_colour);
    end
  end

  `PBLC_ASSERT_SAME(a_lit_has_flashes, clk, rst, flash_lit, playing_flashes != 8'd0, "lit, no count")
  `PBLC_ASSERT_SAME(a_rem_below_span, clk, rst, cmd.fin, rem < span_q, "remainder out of range")
  `PBLC_ASSERT_SAME(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd), "more than one command at once")

endmodule

// ===== design/pblc_ctrl.sv =====
// controller: request handshake, step sequencing and result handshake
// depends on pblc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "proximity_blink_led_controller_assert.svh"

module pblc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  output logic                 led_valid,
  input  logic                 led_stall,
  output pblc_pkg::dp_cmd_t    cmd,
  input  pblc_pkg::dp_status_t status
);
  import pblc_pkg::*;

  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_last;

  assign div_last   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign item_stall = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!led_valid || !led_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // divider step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.exec) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= 1'b0;
    end else if (cmd.load_out) begin
      led_valid <= 1'b1;
    end else if (!led_stall) begin
      led_valid <= 1'b0;
    end
  end

  `PBLC_ASSERT_NEXT(a_take_exec, clk, rst, cmd.take, state == ST_EXEC, "accepted request not executed")
  `PBLC_ASSERT_NEXT(a_div_fin, clk, rst, (state == ST_DIV) && div_last, state == ST_FIN, "divider overran its step count")
  `PBLC_ASSERT_NEXT(a_load_valid, clk, rst, cmd.load_out, led_valid && (state == ST_IDLE), "result not presented after load")

endmodule

// ===== design/proximity_blink_led_controller.sv =====
// Proximity blink LED controller. Each accepted request (millisecond tick,
// detection notice or flash request) yields exactly one result: the LED colour
// after the request is handled. Most requests go through accept, execute and
// load into the result register. A tick that ends a wait and starts a proximity
// blink half period with rssi_near above rssi_far adds the interpolation
// divider (one quotient bit per cycle over 24 steps) and a finish step. A new
// request is accepted while an earlier result still waits in the output register.
// Configuration registers sit at byte addresses 0, 4, ... 20 on the APB port;
// the user must write them only while idle, the block does not enforce this.
// top level: configuration registers, controller and datapath
// depends on pblc_pkg, pblc_ctrl and pblc_dp
`timescale 1ns / 1ps

module proximity_blink_led_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  pblc_pkg::item_t item,
  output logic            led_valid,
  input  logic            led_stall,
  output pblc_pkg::led_t  led,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import pblc_pkg::*;

  cfg_t       cfg;
  cfg_reg_t   reg_sel;
  logic       cfg_write;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rssi_near    <= -8'sd40;
      cfg.rssi_far     <= -8'sd90;
      cfg.fast_half_ms <= 16'd50;
      cfg.slow_half_ms <= 16'd500;
      cfg.hold_ms      <= 16'd3000;
      cfg.brightness   <= 8'd32;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_RSSI_NEAR:    cfg.rssi_near    <= pwdata[7:0];
        REG_RSSI_FAR:     cfg.rssi_far     <= pwdata[7:0];
        REG_FAST_HALF_MS: cfg.fast_half_ms <= pwdata[15:0];
        REG_SLOW_HALF_MS: cfg.slow_half_ms <= pwdata[15:0];
        REG_HOLD_MS:      cfg.hold_ms      <= pwdata[15:0];
        REG_BRIGHTNESS:   cfg.brightness   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      REG_RSSI_NEAR:    prdata = {24'd0, cfg.rssi_near};
      REG_RSSI_FAR:     prdata = {24'd0, cfg.rssi_far};
      REG_FAST_HALF_MS: prdata = {16'd0, cfg.fast_half_ms};
      REG_SLOW_HALF_MS: prdata = {16'd0, cfg.slow_half_ms};
      REG_HOLD_MS:      prdata = {16'd0, cfg.hold_ms};
      REG_BRIGHTNESS:   prdata = {24'd0, cfg.brightness};
      default:          prdata = 32'd0;
    endcase
  end

  // sequencing
  pblc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .led_valid  (led_valid),
    .led_stall  (led_stall),
    .cmd        (cmd),
    .status     (status)
  );

  // led state and arithmetic
  pblc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .led    (led)
  );

endmodule
